FILE: hw/rtl/csvx_pkg.sv
// csvx_pkg: shared types and constants of the csv two-column code extractor
// used by every module under hw/rtl; depends on nothing
`default_nettype none

package csvx_pkg;

	localparam int CODE_CHARS_DEF = 3;
	localparam int CODE_W         = 24;
	localparam int COL_W          = 8;
	localparam int CFG_IDX_W      = 1;

	localparam logic [COL_W-1:0] FIRST_COLUMN_RST  = 8'd17;
	localparam logic [COL_W-1:0] SECOND_COLUMN_RST = 8'd18;
	localparam logic [COL_W-1:0] COMMA_MAX         = 8'd255;
	localparam logic [7:0]       CHAR_COMMA        = 8'h2C;
	localparam logic [7:0]       CHAR_NUL          = 8'h00;
	localparam logic [15:0]      TEXT_NA           = 16'h4E41;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLUMN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_COLUMN = 1'd1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [COL_W-1:0] first_column;
		logic [COL_W-1:0] second_column;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [CODE_W-1:0] first_code;
		logic [CODE_W-1:0] second_code;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/csv_two_column_code_extractor.sv
// Takes one byte of a comma-separated line per cycle while in_stall is low and gives one
// result item on the byte marked line_end: the two codes captured at the configured comma
// numbers and a status (ok, invalid, too long). A new byte is accepted every cycle unless
// in_stall is high; each byte passes an input register and the combinational line-state
// update, then a line's result goes to the result register. in_stall rises only when a
// line-ending byte is waiting while the result register still holds an untaken result.
// Column registers are written through the cfg channel, which is always ready; write them
// only while no line is in progress. Depends on csvx_pkg, csvx_cfg_regs, csvx_line_parser.
`default_nettype none

module csv_two_column_code_extractor import csvx_pkg::*; #(
	parameter int MAX_CODE_CHARS = CODE_CHARS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           text_byte,
	input  wire logic                 line_end,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                status,
	output logic [CODE_W-1:0]         first_code,
	output logic [CODE_W-1:0]         second_code,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COL_W-1:0]     cfg_data
);

	cfg_t       cfg;
	result_t    result;
	logic       valid_s1;
	logic [7:0] text_byte_s1;
	logic       line_end_s1;
	logic       go_s1;
	logic       out_valid_q;
	result_t    result_q;

	csvx_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a line-ending item waits only when the result register is still full and out_stall is high
	assign go_s1    = valid_s1 && !(line_end_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			text_byte_s1 <= text_byte;
			line_end_s1  <= line_end;
		end
	end

	csvx_line_parser #(
		.MAX_CODE_CHARS (MAX_CODE_CHARS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.go        (go_s1),
		.text_byte (text_byte_s1),
		.line_end  (line_end_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (go_s1 && line_end_s1) || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && line_end_s1)
			result_q <= result;
	end

	assign out_valid   = out_valid_q;
	assign status      = result_q.status;
	assign first_code  = result_q.first_code;
	assign second_code = result_q.second_code;

endmodule

`default_nettype wire

FILE: hw/rtl/csvx_cfg_regs.sv
// csvx_cfg_regs: column number registers behind the configuration write channel
// depends on csvx_pkg
`default_nettype none

module csvx_cfg_regs import csvx_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COL_W-1:0]     cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_column  <= FIRST_COLUMN_RST;
			cfg_q.second_column <= SECOND_COLUMN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FIRST_COLUMN:  cfg_q.first_column  <= cfg_data;
				REG_SECOND_COLUMN: cfg_q.second_column <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/csvx_line_parser.sv
// csvx_line_parser: per-line state and the one-byte update that builds the result
// depends on csvx_pkg; fed from the input register of the top level
`default_nettype none

module csvx_line_parser import csvx_pkg::*; #(
	parameter int MAX_CODE_CHARS = CODE_CHARS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             go,
	input  wire logic [7:0]       text_byte,
	input  wire logic             line_end,
	output result_t               result
);

	localparam int CHARS_W = 8 * MAX_CODE_CHARS;
	localparam int LEN_W   = $clog2(MAX_CODE_CHARS + 2);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_CODE_CHARS);
	localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(MAX_CODE_CHARS + 1);
	localparam logic [LEN_W-1:0] LEN_NA   = LEN_W'(2);
	// "NA" placed at the first two positions; the second letter drops off for one-char codes
	localparam logic [CHARS_W+15:0] NA_WIDE = {{CHARS_W{1'b0}}, TEXT_NA} << CHARS_W;
	localparam logic [CHARS_W-1:0]  NA_CODE = NA_WIDE[CHARS_W+15:16];

	logic [COL_W-1:0]   comma_count_q, comma_count_d, comma_inc;
	logic [LEN_W-1:0]   field_length_q, field_length_d;
	logic [CHARS_W-1:0] field_chars_q, field_chars_d;
	logic [CHARS_W-1:0] first_held_q, first_held_d;
	logic [CHARS_W-1:0] second_held_q, second_held_d;
	logic [1:0]         found_marks_q, found_marks_d;
	logic [1:0]         line_status_q, line_status_d;
	logic               stopped_q, stopped_d;
	logic [1:0]         res_status;
	logic [CHARS_W+CODE_W-1:0] first_ext, second_ext;

	always_comb begin
		comma_count_d  = comma_count_q;
		field_length_d = field_length_q;
		field_chars_d  = field_chars_q;
		first_held_d   = first_held_q;
		second_held_d  = second_held_q;
		found_marks_d  = found_marks_q;
		line_status_d  = line_status_q;
		stopped_d      = stopped_q;
		comma_inc      = comma_count_q + 8'd1;

		if (!stopped_q && line_status_q == ST_OK) begin
			if (text_byte == CHAR_NUL) begin
				stopped_d = 1'b1;
			end else if (text_byte == CHAR_COMMA) begin
				if (comma_count_q != COMMA_MAX) begin
					comma_count_d = comma_inc;
					if (comma_inc == cfg.first_column || comma_inc == cfg.second_column) begin
						if (field_length_q == '0) begin
							line_status_d = ST_INVALID;
						end else if (field_length_q > LEN_MAX) begin
							line_status_d = ST_TOO_LONG;
						end else if (field_length_q == LEN_NA && field_chars_q == NA_CODE) begin
							line_status_d = ST_INVALID;
						end else if (comma_inc == cfg.first_column) begin
							first_held_d     = field_chars_q;
							found_marks_d[0] = 1'b1;
						end else begin
							second_held_d    = field_chars_q;
							found_marks_d[1] = 1'b1;
						end
					end
				end
				field_length_d = '0;
				field_chars_d  = '0;
			end else if (field_length_q < LEN_MAX) begin
				// characters fill from the top byte down
				for (int i = 0; i < MAX_CODE_CHARS; i++) begin
					if (field_length_q == LEN_W'(i))
						field_chars_d[8*(MAX_CODE_CHARS-1-i) +: 8] = text_byte;
				end
				field_length_d = field_length_q + LEN_W'(1);
			end else begin
				field_length_d = LEN_OVER;
			end
		end

		res_status = line_status_d;
		if (res_status == ST_OK && found_marks_d != 2'b11)
			res_status = ST_INVALID;
	end

	assign first_ext  = {{CODE_W{1'b0}}, first_held_d};
	assign second_ext = {{CODE_W{1'b0}}, second_held_d};

	always_comb begin
		result.status      = res_status;
		result.first_code  = (res_status == ST_OK) ? first_ext[CODE_W-1:0]  : '0;
		result.second_code = (res_status == ST_OK) ? second_ext[CODE_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comma_count_q  <= '0;
			field_length_q <= '0;
			field_chars_q  <= '0;
			first_held_q   <= '0;
			second_held_q  <= '0;
			found_marks_q  <= '0;
			line_status_q  <= ST_OK;
			stopped_q      <= 1'b0;
		end else if (go) begin
			if (line_end) begin
				comma_count_q  <= '0;
				field_length_q <= '0;
				field_chars_q  <= '0;
				first_held_q   <= '0;
				second_held_q  <= '0;
				found_marks_q  <= '0;
				line_status_q  <= ST_OK;
				stopped_q      <= 1'b0;
			end else begin
				comma_count_q  <= comma_count_d;
				field_length_q <= field_length_d;
				field_chars_q  <= field_chars_d;
				first_held_q   <= first_held_d;
				second_held_q  <= second_held_d;
				found_marks_q  <= found_marks_d;
				line_status_q  <= line_status_d;
				stopped_q      <= stopped_d;
			end
		end
	end

endmodule

`default_nettype wire
